FILE: rtl/core/vna_pkg.sv
// Shared types, widths and helpers for the vertex normal accumulation block.
// No dependencies.
package vna_pkg;

  localparam int IDX_W = 17;
  localparam int POS_W = 20;
  localparam int ACC_W = 48;
  localparam int DIF_W = POS_W + 1;
  localparam int PRD_W = 2 * DIF_W;
  localparam int N_W   = PRD_W + 1;

  localparam int DEF_MAX_VERTICES = 65536;

  localparam logic [1:0] FN_WRITE_POS = 2'd0;
  localparam logic [1:0] FN_ADD_TRI   = 2'd1;
  localparam logic [1:0] FN_READ_NORM = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } vert_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
  } acc_t;

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [N_W-1:0] d);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(acc) + (ACC_W+1)'(d);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/vertex_normal_accumulation.sv
// Vertex normal accumulation top level: position and accumulator memories, sequencer.
// Depends on vna_pkg and vna_cross.
//
// After reset the block sweeps all MAX_VERTICES accumulator entries to zero, one entry per
// cycle, and holds in_stall high meanwhile. Afterwards one item is worked on at a time. A
// position write goes straight into the position memory. A normal read fetches the
// accumulator entry and waits until the output register is free. For a triangle, both
// memories have one read port, so the three corner positions are read in turn, the cross
// product passes a 3-stage pipeline, and the three accumulator read-modify-writes follow
// back to back, with forwarding when corners repeat. Position writes and triangles with an
// index out of range, and unused codes, are ignored; an out-of-range read returns zero.
module vertex_normal_accumulation #(
  parameter int MAX_VERTICES = vna_pkg::DEF_MAX_VERTICES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         func,
  input  logic [vna_pkg::IDX_W-1:0]          index_a,
  input  logic [vna_pkg::IDX_W-1:0]          index_b,
  input  logic [vna_pkg::IDX_W-1:0]          index_c,
  input  logic signed [vna_pkg::POS_W-1:0]   pos_x,
  input  logic signed [vna_pkg::POS_W-1:0]   pos_y,
  input  logic signed [vna_pkg::POS_W-1:0]   pos_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [vna_pkg::ACC_W-1:0]   normal_x,
  output logic signed [vna_pkg::ACC_W-1:0]   normal_y,
  output logic signed [vna_pkg::ACC_W-1:0]   normal_z
);
  import vna_pkg::*;

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int SLOT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_VERTICES - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_VB, S_VC, S_DIFF, S_MUL, S_SUB,
    S_ACC_B, S_ACC_C, S_ACC_END, S_RESP
  } state_t;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    in_range = (idx != '0) && ((SLOT_W+1)'(idx) <= (SLOT_W+1)'(MAX_VERTICES));
  endfunction

  function automatic logic [ADDR_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [SLOT_W-1:0] s;
    s = SLOT_W'(idx) - SLOT_W'(1);
    slot_of = s[ADDR_W-1:0];
  endfunction

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] slot_a, slot_b, slot_c;
  logic              rd_ok;
  vert_t             pa, pb;
  logic              fwd;
  acc_t              fwd_data;

  vert_t             vert_mem [MAX_VERTICES];
  vert_t             vert_rd;
  logic              vert_we, vert_re;
  logic [ADDR_W-1:0] vert_raddr;

  acc_t              acc_mem [MAX_VERTICES];
  acc_t              acc_rd, acc_cur, acc_new, acc_wdata;
  logic              acc_we, acc_re;
  logic [ADDR_W-1:0] acc_raddr, acc_waddr;

  logic signed [N_W-1:0] nx, ny, nz;

  logic accept, ok_a, ok_tri, out_load;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ok_a     = in_range(index_a);
  assign ok_tri   = ok_a && in_range(index_b) && in_range(index_c);
  assign out_load = (state == S_RESP) && (!out_valid || !out_stall);

  vna_cross u_cross (
    .clk   (clk),
    .pos_a (pa),
    .pos_b (pb),
    .pos_c (vert_rd),
    .nx    (nx),
    .ny    (ny),
    .nz    (nz)
  );

  // position memory
  always_comb begin
    vert_we = accept && (func == FN_WRITE_POS) && ok_a;
    vert_re = (accept && (func == FN_ADD_TRI) && ok_tri) || (state == S_VB) ||
              (state == S_VC);
    case (state)
      S_VB:    vert_raddr = slot_b;
      S_VC:    vert_raddr = slot_c;
      default: vert_raddr = slot_of(index_a);
    endcase
  end

  always_ff @(posedge clk) begin
    if (vert_we) begin
      vert_mem[slot_of(index_a)] <= '{x: pos_x, y: pos_y, z: pos_z};
    end
    if (vert_re) begin
      vert_rd <= vert_mem[vert_raddr];
    end
  end

  // accumulator memory, read-modify-write
  always_comb begin
    acc_cur   = fwd ? fwd_data : acc_rd;
    acc_new.x = sat_add(acc_cur.x, nx);
    acc_new.y = sat_add(acc_cur.y, ny);
    acc_new.z = sat_add(acc_cur.z, nz);
    acc_re    = 1'b0;
    acc_raddr = slot_of(index_a);
    acc_we    = 1'b0;
    acc_waddr = slot_of(index_a);
    acc_wdata = '0;
    case (state)
      S_CLR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr;
      end
      S_IDLE: begin
        acc_re = accept && (func == FN_READ_NORM) && ok_a;
        acc_we = acc_re;
      end
      S_SUB: begin
        acc_re    = 1'b1;
        acc_raddr = slot_a;
      end
      S_ACC_B: begin
        acc_re    = 1'b1;
        acc_raddr = slot_b;
        acc_we    = 1'b1;
        acc_waddr = slot_a;
        acc_wdata = acc_new;
      end
      S_ACC_C: begin
        acc_re    = 1'b1;
        acc_raddr = slot_c;
        acc_we    = 1'b1;
        acc_waddr = slot_b;
        acc_wdata = acc_new;
      end
      S_ACC_END: begin
        acc_we    = 1'b1;
        acc_waddr = slot_c;
        acc_wdata = acc_new;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (acc_re) begin
      acc_rd <= acc_mem[acc_raddr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      fwd       <= 1'b0;
    end else begin
      fwd      <= ((state == S_ACC_B) || (state == S_ACC_C)) && (acc_raddr == acc_waddr);
      fwd_data <= acc_wdata;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            slot_a <= slot_of(index_a);
            slot_b <= slot_of(index_b);
            slot_c <= slot_of(index_c);
            rd_ok  <= ok_a;
            if ((func == FN_ADD_TRI) && ok_tri) begin
              state <= S_VB;
            end else if (func == FN_READ_NORM) begin
              state <= S_RESP;
            end
          end
        end
        S_VB: begin
          pa    <= vert_rd;
          state <= S_VC;
        end
        S_VC: begin
          pb    <= vert_rd;
          state <= S_DIFF;
        end
        S_DIFF:    state <= S_MUL;
        S_MUL:     state <= S_SUB;
        S_SUB:     state <= S_ACC_B;
        S_ACC_B:   state <= S_ACC_C;
        S_ACC_C:   state <= S_ACC_END;
        S_ACC_END: state <= S_IDLE;
        S_RESP: begin
          if (out_load) begin
            out_valid <= 1'b1;
            normal_x  <= rd_ok ? acc_rd.x : '0;
            normal_y  <= rd_ok ? acc_rd.y : '0;
            normal_z  <= rd_ok ? acc_rd.z : '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR && clr_addr != CLR_LAST |=>
      state == S_CLR && clr_addr == $past(clr_addr) + 1'b1)
    else $error("clearing pass left early or skipped an entry");

  a_acc_sequence: assert property (@(posedge clk) disable iff (rst)
    state == S_SUB |=> state == S_ACC_B ##1 state == S_ACC_C ##1 state == S_ACC_END)
    else $error("accumulator update sequence broken");

  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    fwd |-> $past(acc_we) && $past(acc_re) && $past(acc_waddr) == $past(acc_raddr))
    else $error("forwarding without a colliding write");

  a_bad_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_load && !rd_ok |=> out_valid && normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("out of range read did not return zero");

endmodule

FILE: rtl/core/vna_cross.sv
// Three-stage cross product pipeline: edge differences, products, final subtract.
// Free running; depends on vna_pkg.
module vna_cross (
  input  logic                             clk,
  input  vna_pkg::vert_t                   pos_a,
  input  vna_pkg::vert_t                   pos_b,
  input  vna_pkg::vert_t                   pos_c,
  output logic signed [vna_pkg::N_W-1:0]   nx,
  output logic signed [vna_pkg::N_W-1:0]   ny,
  output logic signed [vna_pkg::N_W-1:0]   nz
);
  import vna_pkg::*;

  logic signed [DIF_W-1:0] u1, u2, u3, w1, w2, w3;
  logic signed [PRD_W-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;

  always_ff @(posedge clk) begin
    u1 <= DIF_W'(pos_a.x) - DIF_W'(pos_b.x);
    u2 <= DIF_W'(pos_a.y) - DIF_W'(pos_b.y);
    u3 <= DIF_W'(pos_a.z) - DIF_W'(pos_b.z);
    w1 <= DIF_W'(pos_a.x) - DIF_W'(pos_c.x);
    w2 <= DIF_W'(pos_a.y) - DIF_W'(pos_c.y);
    w3 <= DIF_W'(pos_a.z) - DIF_W'(pos_c.z);

    p_yz <= PRD_W'(u2) * PRD_W'(w3);
    p_zy <= PRD_W'(u3) * PRD_W'(w2);
    p_zx <= PRD_W'(u3) * PRD_W'(w1);
    p_xz <= PRD_W'(u1) * PRD_W'(w3);
    p_xy <= PRD_W'(u1) * PRD_W'(w2);
    p_yx <= PRD_W'(u2) * PRD_W'(w1);

    nx <= N_W'(p_yz) - N_W'(p_zy);
    ny <= N_W'(p_zx) - N_W'(p_xz);
    nz <= N_W'(p_xy) - N_W'(p_yx);
  end

endmodule

FILE: tb/vertex_normal_accumulation_test.sv
// Self-checking testbench for vertex_normal_accumulation: drives position writes, triangles
// and normal reads, and checks each read against a built-in accumulator model.
// Depends on vna_pkg and the vertex_normal_accumulation RTL.
`timescale 1ns / 1ps

module vertex_normal_accumulation_test;
  import vna_pkg::*;

  localparam int VERTEX_COUNT = DEF_MAX_VERTICES;
  localparam int INDEX_TOP    = (1 << IDX_W) - 1;
  localparam int POOL_SIZE    = 16;
  localparam int PHASE_OPS    = 340;
  localparam int QUIET_LIMIT  = 4 * VERTEX_COUNT;
  localparam int TAIL_CYCLES  = 20;

  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic signed [POS_W-1:0] POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] NORM_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] NORM_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct {
    logic [1:0]       fn;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic [IDX_W-1:0] ic;
    vert_t            pos;
  } mesh_op_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              func = '0;
  logic [IDX_W-1:0]        index_a = '0;
  logic [IDX_W-1:0]        index_b = '0;
  logic [IDX_W-1:0]        index_c = '0;
  logic signed [POS_W-1:0] pos_x = '0;
  logic signed [POS_W-1:0] pos_y = '0;
  logic signed [POS_W-1:0] pos_z = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [ACC_W-1:0] normal_x;
  logic signed [ACC_W-1:0] normal_y;
  logic signed [ACC_W-1:0] normal_z;

  mesh_op_t mesh_ops[$];
  acc_t     expected_normals[$];
  vert_t    vertex_pos[int];
  acc_t     normal_sum[int];

  bit       gen_written[int];
  int       written_list[$];
  int       vertex_pool[POOL_SIZE];
  int       op_count = 0;

  int       send_idle_pct = 23;
  int       recv_stall_pct = 59;
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  mesh_op_t next_op;
  mesh_op_t seen_op;
  acc_t     want;

  vertex_normal_accumulation dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .index_a  (index_a),
    .index_b  (index_b),
    .index_c  (index_c),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .normal_x (normal_x),
    .normal_y (normal_y),
    .normal_z (normal_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- accumulator model ----------------

  function automatic bit in_range(logic [IDX_W-1:0] i);
    return (i != 0) && (int'(i) <= VERTEX_COUNT);
  endfunction

  function automatic vert_t vertex_at(logic [IDX_W-1:0] i);
    if (vertex_pos.exists(int'(i))) return vertex_pos[int'(i)];
    return '0;
  endfunction

  function automatic acc_t sum_at(logic [IDX_W-1:0] i);
    if (normal_sum.exists(int'(i))) return normal_sum[int'(i)];
    return '0;
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_add(logic signed [ACC_W-1:0] acc,
                                                        logic signed [ACC_W-1:0] d);
    logic signed [ACC_W+1:0] s;
    s = acc + d;
    if (s > NORM_MAX) return NORM_MAX;
    if (s < NORM_MIN) return NORM_MIN;
    return s[ACC_W-1:0];
  endfunction

  function automatic void add_to_corner(logic [IDX_W-1:0] i, acc_t n);
    acc_t s;
    s = sum_at(i);
    s.x = clamp_add(s.x, n.x);
    s.y = clamp_add(s.y, n.y);
    s.z = clamp_add(s.z, n.z);
    normal_sum[int'(i)] = s;
  endfunction

  function automatic void apply_mesh_op(mesh_op_t op);
    vert_t va, vb, vc;
    logic signed [DIF_W-1:0] u1, u2, u3, w1, w2, w3;
    acc_t n;
    acc_t blank;
    blank = '0;
    case (op.fn)
      FN_WRITE_POS: begin
        if (in_range(op.ia)) vertex_pos[int'(op.ia)] = op.pos;
      end
      FN_ADD_TRI: begin
        if (in_range(op.ia) && in_range(op.ib) && in_range(op.ic)) begin
          va = vertex_at(op.ia);
          vb = vertex_at(op.ib);
          vc = vertex_at(op.ic);
          u1 = va.x - vb.x;
          u2 = va.y - vb.y;
          u3 = va.z - vb.z;
          w1 = va.x - vc.x;
          w2 = va.y - vc.y;
          w3 = va.z - vc.z;
          n.x = u2 * w3 - u3 * w2;
          n.y = u3 * w1 - u1 * w3;
          n.z = u1 * w2 - u2 * w1;
          add_to_corner(op.ia, n);
          add_to_corner(op.ib, n);
          add_to_corner(op.ic, n);
        end
      end
      FN_READ_NORM: begin
        if (in_range(op.ia)) begin
          expected_normals.insert(expected_normals.size(), sum_at(op.ia));
          normal_sum.delete(int'(op.ia));
        end else begin
          expected_normals.insert(expected_normals.size(), blank);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------- stimulus construction ----------------

  function automatic logic [IDX_W-1:0] idx_bits(int i);
    logic [31:0] w;
    w = i;
    return w[IDX_W-1:0];
  endfunction

  function automatic vert_t random_vert();
    logic [31:0] r;
    vert_t v;
    r = $urandom;
    v.x = r[POS_W-1:0];
    r = $urandom;
    v.y = r[POS_W-1:0];
    r = $urandom;
    v.z = r[POS_W-1:0];
    return v;
  endfunction

  function automatic mesh_op_t noisy_op(logic [1:0] fn);
    mesh_op_t op;
    op.fn = fn;
    op.ia = idx_bits($urandom_range(0, INDEX_TOP));
    op.ib = idx_bits($urandom_range(0, INDEX_TOP));
    op.ic = idx_bits($urandom_range(0, INDEX_TOP));
    op.pos = random_vert();
    return op;
  endfunction

  function automatic void push_op(mesh_op_t op);
    mesh_ops.insert(mesh_ops.size(), op);
    if (op.fn == FN_WRITE_POS && in_range(op.ia)) begin
      op_count++;
      if (!gen_written.exists(int'(op.ia))) begin
        gen_written[int'(op.ia)] = 1'b1;
        written_list.insert(written_list.size(), int'(op.ia));
      end
    end else if (op.fn == FN_ADD_TRI && in_range(op.ia) && in_range(op.ib) && in_range(op.ic))
      op_count++;
    else if (op.fn == FN_READ_NORM)
      op_count++;
  endfunction

  function automatic void push_write(int i, vert_t p);
    mesh_op_t op;
    op = noisy_op(FN_WRITE_POS);
    op.ia = idx_bits(i);
    op.pos = p;
    push_op(op);
  endfunction

  function automatic void push_tri(int a, int b, int c);
    mesh_op_t op;
    op = noisy_op(FN_ADD_TRI);
    op.ia = idx_bits(a);
    op.ib = idx_bits(b);
    op.ic = idx_bits(c);
    push_op(op);
  endfunction

  function automatic void push_read(int i);
    mesh_op_t op;
    op = noisy_op(FN_READ_NORM);
    op.ia = idx_bits(i);
    push_op(op);
  endfunction

  function automatic int any_written();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  function automatic int bad_index();
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(VERTEX_COUNT + 1, INDEX_TOP);
  endfunction

  function automatic void build_vertex_pool();
    bit taken[int];
    int n;
    int cand;
    vertex_pool[0] = 1;
    vertex_pool[1] = 2;
    vertex_pool[2] = 3;
    vertex_pool[3] = 4;
    vertex_pool[4] = 5;
    vertex_pool[5] = VERTEX_COUNT - 1;
    vertex_pool[6] = VERTEX_COUNT;
    n = 7;
    while (n < POOL_SIZE) begin
      cand = $urandom_range(6, VERTEX_COUNT - 2);
      if (!taken.exists(cand)) begin
        taken[cand] = 1'b1;
        vertex_pool[n] = cand;
        n++;
      end
    end
  endfunction

  function automatic void directed_ops();
    push_write(1, '{POS_MAX, POS_MIN, '0});
    push_write(2, '{POS_MIN, POS_MAX, POS_MAX});
    push_write(3, '{'0, '0, POS_MIN});
    push_write(VERTEX_COUNT, '{POS_MIN, POS_MIN, POS_MIN});
    push_write(4, '{POS_MAX, POS_MAX, POS_MAX});
    push_tri(1, 2, 3);
    push_tri(VERTEX_COUNT, 1, 4);
    push_tri(4, 4, 1);
    push_tri(1, 2, VERTEX_COUNT);
    // out-of-range indices: ignored writes and triangles
    push_write(0, random_vert());
    push_write(VERTEX_COUNT + 1, random_vert());
    push_write(INDEX_TOP, random_vert());
    push_tri(1, 0, 2);
    push_tri(2, 3, VERTEX_COUNT + 1);
    push_tri(INDEX_TOP, 1, 4);
    push_op(noisy_op(FN_UNUSED));
    push_read(0);
    push_read(INDEX_TOP);
    push_read(1);
    push_read(2);
    push_read(3);
    push_read(4);
    push_read(VERTEX_COUNT);
    push_read(1);
    push_read(77);
  endfunction

  // Same triangle many times to drive one normal axis into the clamp, then a few
  // opposite-facing ones to come back off it.
  function automatic void saturation_burst(bit negative);
    int s;
    int a;
    int b;
    int c;
    vert_t apex;
    vert_t pb;
    vert_t pc;
    s = $urandom_range(0, POOL_SIZE - 3);
    a = vertex_pool[s];
    b = vertex_pool[s + 1];
    c = vertex_pool[s + 2];
    apex = '{POS_MAX, POS_MAX, POS_MAX};
    pb = apex;
    pc = apex;
    case ($urandom_range(0, 2))
      0: begin
        pb.y = POS_MIN;
        pc.z = POS_MIN;
      end
      1: begin
        pb.z = POS_MIN;
        pc.x = POS_MIN;
      end
      default: begin
        pb.x = POS_MIN;
        pc.y = POS_MIN;
      end
    endcase
    push_write(a, apex);
    push_write(b, pb);
    push_write(c, pc);
    repeat ($urandom_range(140, 200)) begin
      if (negative) push_tri(a, c, b);
      else push_tri(a, b, c);
    end
    repeat ($urandom_range(1, 3)) begin
      if (negative) push_tri(a, b, c);
      else push_tri(a, c, b);
    end
    push_read(a);
    push_read(b);
    push_read(c);
  endfunction

  function automatic void random_mesh_ops(int target);
    int r;
    int bad;
    while (op_count < target) begin
      r = $urandom_range(0, 99);
      if (r < 28 || written_list.size() == 0) begin
        push_write(vertex_pool[$urandom_range(0, POOL_SIZE - 1)], random_vert());
      end else if (r < 64) begin
        push_tri(any_written(), any_written(), any_written());
      end else if (r < 80) begin
        push_read(vertex_pool[$urandom_range(0, POOL_SIZE - 1)]);
      end else if (r < 84) begin
        push_read($urandom_range(1, VERTEX_COUNT));
      end else if (r < 93) begin
        bad = bad_index();
        case ($urandom_range(0, 4))
          0: push_write(bad, random_vert());
          1: push_tri(bad, any_written(), any_written());
          2: push_tri(any_written(), bad, any_written());
          3: push_tri(any_written(), any_written(), bad);
          default: push_read(bad);
        endcase
      end else begin
        push_op(noisy_op(FN_UNUSED));
      end
    end
  endfunction

  task automatic drain_all();
    while (mesh_ops.size() != 0 || in_valid || expected_normals.size() != 0) @(negedge clk);
  endtask

  // ---------------- driver, receiver, monitor ----------------

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (mesh_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_op = mesh_ops.pop_front();
        func <= next_op.fn;
        index_a <= next_op.ia;
        index_b <= next_op.ib;
        index_c <= next_op.ic;
        pos_x <= next_op.pos.x;
        pos_y <= next_op.pos.y;
        pos_z <= next_op.pos.z;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic check_axis(string name, logic signed [ACC_W-1:0] exp_v,
                            logic signed [ACC_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_normals.size() == 0) begin
          $display("%0t normal with none expected: actual %0d %0d %0d", $time, normal_x,
                   normal_y, normal_z);
          mismatch_count++;
        end else begin
          want = expected_normals.pop_front();
          check_axis("normal_x", want.x, normal_x);
          check_axis("normal_y", want.y, normal_y);
          check_axis("normal_z", want.z, normal_z);
        end
      end
      if (in_valid && !in_stall) begin
        seen_op.fn = func;
        seen_op.ia = index_a;
        seen_op.ib = index_b;
        seen_op.ic = index_c;
        seen_op.pos.x = pos_x;
        seen_op.pos.y = pos_y;
        seen_op.pos.z = pos_z;
        apply_mesh_op(seen_op);
      end
    end
  end

  // covers the accumulator clear after reset as well as a hung block
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("vertex_normal_accumulation: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    build_vertex_pool();
    directed_ops();
    drain_all();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_stall_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_stall_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      saturation_burst(phase == 1 || (phase == 2 && $urandom_range(0, 1) == 1));
      random_mesh_ops(op_count + PHASE_OPS);
      drain_all();
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("vertex_normal_accumulation: match");
    end else begin
      $display("vertex_normal_accumulation: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/vna_pkg.sv
rtl/core/vna_cross.sv
rtl/core/vertex_normal_accumulation.sv
tb/vertex_normal_accumulation_test.sv
